@@ rtl/cte_pkg.sv @@
// ----------------------------------------------------------------------------
// cte_pkg
// Shared types and constants for the connection table engine.
// ----------------------------------------------------------------------------
package cte_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [7:0] LINK_EMPTY_SEARCH = 8'h80;
  localparam int         LINK_TABLE_BIT    = 7;
  localparam int         RES_IDX_W         = 5;

  typedef struct packed {
    logic [31:0] host;
    logic [7:0]  link;
    logic [15:0] sock;
  } entry_t;

  typedef struct packed {
    logic load;
    logic direct;
    logic clr;
    logic rd;
    logic finish;
    logic found;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic rd_more;
    logic hit;
    logic last;
    logic clr_last;
  } status_t;

endpackage

@@ rtl/connection_table_engine_core.sv @@
// ----------------------------------------------------------------------------
// connection_table_engine_core
// Read/write connection tables with lookup, insert and remove by index.
// ----------------------------------------------------------------------------
// Remove, zero-handle insert and unused op: result word in the cycle after accept.
// Lookup/insert scan one entry per cycle through the memory read port: each read
// word is registered and compared, and a match or the last entry gives the result.
// busy stays high until the result cycle; one item in flight at a time.
// Reset: a clearing pass over all 2*2**clog2(ENTRIES) memory words runs with busy high.
// Results cannot be stalled; out_strobe marks each word for one cycle.
module connection_table_engine_core #(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_host,
  input  logic [7:0]  in_link,
  input  logic [15:0] in_socket_id,
  input  logic [4:0]  in_entry_index,
  output logic        out_strobe,
  output logic        out_found,
  output logic        out_table_sel,
  output logic [4:0]  out_result_index
);

  cte_pkg::cmd_t    cmd;
  cte_pkg::status_t status;

  cte_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  cte_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_op            (in_op),
    .in_host          (in_host),
    .in_link          (in_link),
    .in_socket_id     (in_socket_id),
    .in_entry_index   (in_entry_index),
    .out_strobe       (out_strobe),
    .out_found        (out_found),
    .out_table_sel    (out_table_sel),
    .out_result_index (out_result_index)
  );

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("accepted word neither completed nor in progress");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result word while busy");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_found) |-> (out_result_index == '0))
    else $error("nonzero index on miss");

  a_single_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !cmd.load && !cmd.clr)
    else $error("scan finish overlaps load or clear");

endmodule

@@ rtl/cte_ctrl.sv @@
// ----------------------------------------------------------------------------
// cte_ctrl
// Controller: table clear after reset, request accept, table scan sequencing.
// ----------------------------------------------------------------------------
module cte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cte_pkg::status_t  status,
  output cte_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cmd.direct = !status.need_scan;
          if (status.need_scan) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd = status.rd_more;
        if (status.hit) begin
          cmd.finish = 1'b1;
          cmd.found  = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (status.last) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ rtl/cte_datapath.sv @@
// ----------------------------------------------------------------------------
// cte_datapath
// Entry memory for both tables, request registers, scan compare, result word.
// ----------------------------------------------------------------------------
module cte_datapath #(
  parameter int ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cte_pkg::cmd_t     cmd,
  output cte_pkg::status_t  status,
  input  logic [1:0]        in_op,
  input  logic [31:0]       in_host,
  input  logic [7:0]        in_link,
  input  logic [15:0]       in_socket_id,
  input  logic [4:0]        in_entry_index,
  output logic              out_strobe,
  output logic              out_found,
  output logic              out_table_sel,
  output logic [4:0]        out_result_index
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int CW    = IW + 6;

  cte_pkg::entry_t mem [DEPTH];

  logic [1:0]       op_r;
  cte_pkg::entry_t  req_r;
  logic             empty_srch_r;
  logic             any_sock_r;
  logic [IW:0]      cnt_r;
  cte_pkg::entry_t  rd_data_r;
  logic [IW-1:0]    rd_idx_r;
  logic             rd_vld_r;
  logic [AW-1:0]    clr_cnt_r;
  logic             out_strobe_r;
  logic             out_found_r;
  logic             out_sel_r;
  logic [4:0]       out_idx_r;

  logic [IW+4:0]    idx_wide;
  logic [IW+4:0]    hit_wide;
  logic [IW-1:0]    idx_in;
  logic             rm_ok;
  logic             is_remove;
  logic             req_sel;
  logic [AW-1:0]    rd_addr;
  logic [31:0]      tgt_host;
  logic [7:0]       tgt_link;
  logic             eq;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  cte_pkg::entry_t  wr_data;

  assign idx_wide  = (IW + 5)'(in_entry_index);
  assign idx_in    = idx_wide[IW-1:0];
  assign hit_wide  = (IW + 5)'(rd_idx_r);
  assign rm_ok     = CW'(in_entry_index) < CW'(ENTRIES);
  assign is_remove = (in_op == cte_pkg::OP_REMOVE);
  assign req_sel   = req_r.link[cte_pkg::LINK_TABLE_BIT];
  assign rd_addr   = {req_sel, cnt_r[IW-1:0]};
  assign tgt_host  = empty_srch_r ? '0 : req_r.host;
  assign tgt_link  = empty_srch_r ? '0 : req_r.link;
  assign eq        = (rd_data_r.host == tgt_host) && (rd_data_r.link == tgt_link) &&
                     (any_sock_r || (rd_data_r.sock == req_r.sock));

  always_comb begin
    status.need_scan = (in_op == cte_pkg::OP_LOOKUP) ||
                       ((in_op == cte_pkg::OP_INSERT) && (in_socket_id != '0));
    status.rd_more   = cnt_r < (IW + 1)'(ENTRIES);
    status.hit       = rd_vld_r && eq;
    status.last      = rd_vld_r && (rd_idx_r == IW'(ENTRIES - 1));
    status.clr_last  = (clr_cnt_r == '1);
  end

  // single write port: clear pass, remove, insert
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = '0;
    if (cmd.clr) begin
      wr_en = 1'b1;
    end else if (cmd.load && cmd.direct && is_remove && rm_ok) begin
      wr_en   = 1'b1;
      wr_addr = {in_link[cte_pkg::LINK_TABLE_BIT], idx_in};
    end else if (cmd.finish && cmd.found && (op_r == cte_pkg::OP_INSERT)) begin
      wr_en   = 1'b1;
      wr_addr = {req_sel, rd_idx_r};
      wr_data = req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.load) begin
        cnt_r    <= '0;
        rd_vld_r <= 1'b0;
      end else begin
        rd_vld_r <= cmd.rd;
        if (cmd.rd) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      out_strobe_r <= (cmd.load && cmd.direct) || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= in_op;
      req_r.host   <= in_host;
      req_r.link   <= in_link;
      req_r.sock   <= in_socket_id;
      empty_srch_r <= (in_op == cte_pkg::OP_INSERT) ||
                      (in_link == cte_pkg::LINK_EMPTY_SEARCH);
      any_sock_r   <= (in_op == cte_pkg::OP_INSERT) || (in_socket_id == '0);
    end
    if (cmd.rd) begin
      rd_idx_r <= cnt_r[IW-1:0];
    end
    if (cmd.load && cmd.direct) begin
      out_found_r <= is_remove && rm_ok;
      out_sel_r   <= in_link[cte_pkg::LINK_TABLE_BIT];
      out_idx_r   <= (is_remove && rm_ok) ? in_entry_index : '0;
    end else if (cmd.finish) begin
      out_found_r <= cmd.found;
      out_sel_r   <= req_sel;
      out_idx_r   <= cmd.found ? hit_wide[cte_pkg::RES_IDX_W-1:0] : '0;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_found        = out_found_r;
  assign out_table_sel    = out_sel_r;
  assign out_result_index = out_idx_r;

endmodule

@@ tb/tb_connection_table_engine_core.sv @@
// ----------------------------------------------------------------------------
// tb_connection_table_engine_core
// Drives lookup, insert, remove and unused-op words into the connection table
// engine with random idle gaps, predicts each result word from a local copy of
// the read and write tables, and checks every strobed result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_connection_table_engine_core;

  localparam int         ENTRIES    = 32;
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         STALL_MAX  = 1000;
  localparam int         DRAIN_CYC  = 40;

  typedef struct packed {
    logic       found;
    logic       table_sel;
    logic [4:0] index;
  } conn_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [31:0] in_host;
  logic [7:0]  in_link;
  logic [15:0] in_socket_id;
  logic [4:0]  in_entry_index;
  logic        out_strobe;
  logic        out_found;
  logic        out_table_sel;
  logic [4:0]  out_result_index;

  // shadow tables: read table at 0..ENTRIES-1, write table above it
  logic [31:0] conn_host [2*ENTRIES];
  logic [7:0]  conn_link [2*ENTRIES];
  logic [15:0] conn_sock [2*ENTRIES];

  conn_result_t pending_results[$];
  int           errors;
  int           idle_cycles;
  bit           no_idle;
  logic [31:0]  host_pool [4];
  logic [6:0]   link_pool [4];

  connection_table_engine_core #(.ENTRIES(ENTRIES)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_host          (in_host),
    .in_link          (in_link),
    .in_socket_id     (in_socket_id),
    .in_entry_index   (in_entry_index),
    .out_strobe       (out_strobe),
    .out_found        (out_found),
    .out_table_sel    (out_table_sel),
    .out_result_index (out_result_index)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int find_entry(input int base, input logic [31:0] host,
                                    input logic [7:0] link, input logic [15:0] sock);
    for (int i = 0; i < ENTRIES; i++) begin
      if (conn_host[base+i] == host && conn_link[base+i] == link &&
          (sock == 16'd0 || conn_sock[base+i] == sock))
        return i;
    end
    return -1;
  endfunction

  function automatic conn_result_t predict_conn(input logic [1:0] op,
                                                input logic [31:0] host,
                                                input logic [7:0] link,
                                                input logic [15:0] sock,
                                                input logic [4:0] idx);
    conn_result_t r;
    int base;
    int hit;
    r.found     = 1'b0;
    r.table_sel = link[cte_pkg::LINK_TABLE_BIT];
    r.index     = '0;
    base        = link[cte_pkg::LINK_TABLE_BIT] ? ENTRIES : 0;
    case (op)
      cte_pkg::OP_LOOKUP: begin
        if (link == cte_pkg::LINK_EMPTY_SEARCH) hit = find_entry(base, 32'd0, 8'd0, sock);
        else hit = find_entry(base, host, link, sock);
        if (hit >= 0) begin
          r.found = 1'b1;
          r.index = hit[4:0];
        end
      end
      cte_pkg::OP_INSERT: begin
        if (sock != 16'd0) begin
          hit = find_entry(base, 32'd0, 8'd0, 16'd0);
          if (hit >= 0) begin
            conn_host[base+hit] = host;
            conn_link[base+hit] = link;
            conn_sock[base+hit] = sock;
            r.found = 1'b1;
            r.index = hit[4:0];
          end
        end
      end
      cte_pkg::OP_REMOVE: begin
        if (int'(idx) < ENTRIES) begin
          conn_host[base+idx] = '0;
          conn_link[base+idx] = '0;
          conn_sock[base+idx] = '0;
          r.found = 1'b1;
          r.index = idx;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [31:0] host,
                           input logic [7:0] link, input logic [15:0] sock,
                           input logic [4:0] idx);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    repeat (gap) begin
      @(negedge clk);
      start          = 1'b0;
      in_op          = 2'($urandom);
      in_host        = $urandom;
      in_link        = 8'($urandom);
      in_socket_id   = 16'($urandom);
      in_entry_index = 5'($urandom);
    end
    @(negedge clk);
    start          = 1'b1;
    in_op          = op;
    in_host        = host;
    in_link        = link;
    in_socket_id   = sock;
    in_entry_index = idx;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_conn(op, host, link, sock, idx));
  endtask

  // result checker
  always @(posedge clk) begin
    conn_result_t exp_r;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected: found=%0d sel=%0d idx=%0d",
                 $time, out_found, out_table_sel, out_result_index);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_found !== exp_r.found) begin
          $display("%0t: found mismatch: expected %0d, actual %0d",
                   $time, exp_r.found, out_found);
          errors++;
        end
        if (out_table_sel !== exp_r.table_sel) begin
          $display("%0t: table_sel mismatch: expected %0d, actual %0d",
                   $time, exp_r.table_sel, out_table_sel);
          errors++;
        end
        if (out_result_index !== exp_r.index) begin
          $display("%0t: result_index mismatch: expected %0d, actual %0d",
                   $time, exp_r.index, out_result_index);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("%0t: timeout", $time);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic test_directed();
    no_idle = 1'b0;
    send_word(cte_pkg::OP_LOOKUP, 32'h0, 8'h00, 16'h0000, 5'd0);
    send_word(cte_pkg::OP_LOOKUP, 32'h5a5a5a5a, cte_pkg::LINK_EMPTY_SEARCH, 16'h0000, 5'd0);
    send_word(cte_pkg::OP_INSERT, 32'hffffffff, 8'h01, 16'h0000, 5'd0);
    send_word(cte_pkg::OP_INSERT, 32'hffffffff, 8'hff, 16'hffff, 5'd31);
    send_word(cte_pkg::OP_INSERT, 32'h0, 8'h00, 16'h0001, 5'd0);
    send_word(cte_pkg::OP_INSERT, 32'h12345678, 8'h7f, 16'h8000, 5'd0);
    send_word(cte_pkg::OP_LOOKUP, 32'hffffffff, 8'hff, 16'h0000, 5'd0);
    send_word(cte_pkg::OP_LOOKUP, 32'hffffffff, 8'hff, 16'hffff, 5'd0);
    send_word(cte_pkg::OP_LOOKUP, 32'hffffffff, 8'hff, 16'h1234, 5'd0);
    send_word(cte_pkg::OP_LOOKUP, 32'hffffffff, cte_pkg::LINK_EMPTY_SEARCH, 16'h0000, 5'd0);
    send_word(cte_pkg::OP_LOOKUP, 32'h0, cte_pkg::LINK_EMPTY_SEARCH, 16'h0005, 5'd0);
    send_word(cte_pkg::OP_LOOKUP, 32'h0, 8'h00, 16'h0001, 5'd0);
    send_word(cte_pkg::OP_REMOVE, 32'h0, cte_pkg::LINK_EMPTY_SEARCH, 16'h0000, 5'd31);
    send_word(cte_pkg::OP_REMOVE, 32'hffffffff, 8'h00, 16'hffff, 5'd0);
    send_word(cte_pkg::OP_LOOKUP, 32'h12345678, 8'h7f, 16'h0000, 5'd0);
    send_word(OP_UNUSED, 32'hffffffff, 8'hff, 16'hffff, 5'd31);
    send_word(OP_UNUSED, 32'h0, 8'h00, 16'h0000, 5'd0);
    send_word(cte_pkg::OP_REMOVE, 32'h0, 8'hff, 16'h0000, 5'd0);
    send_word(cte_pkg::OP_LOOKUP, 32'hffffffff, 8'hff, 16'h0000, 5'd0);
  endtask

  // fill the write table back to back, then overflow it
  task automatic test_table_full();
    logic [4:0] victim;
    no_idle = 1'b1;
    for (int i = 0; i < ENTRIES + 2; i++)
      send_word(cte_pkg::OP_INSERT, $urandom, {1'b1, 7'($urandom)},
                16'($urandom_range(1, 65535)), 5'($urandom));
    send_word(cte_pkg::OP_LOOKUP, $urandom, cte_pkg::LINK_EMPTY_SEARCH, 16'h0000, 5'd0);
    victim = 5'($urandom);
    send_word(cte_pkg::OP_REMOVE, $urandom, {1'b1, 7'($urandom)}, 16'($urandom), victim);
    send_word(cte_pkg::OP_INSERT, $urandom, 8'h80 | 8'($urandom), 16'hbeef, 5'($urandom));
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    int          insert_pct [5];
    int          r;
    int          k;
    logic [1:0]  op;
    logic [31:0] host;
    logic [7:0]  link;
    logic [15:0] sock;
    logic        sel;
    insert_pct = '{60, 15, 70, 25, 45};
    host_pool  = '{32'h0, 32'hffffffff, $urandom, $urandom};
    link_pool  = '{7'h00, 7'h7f, 7'($urandom), 7'($urandom)};
    for (int round = 0; round < 5; round++) begin
      no_idle = (round == 3);
      for (int n = 0; n < 100; n++) begin
        r    = $urandom_range(0, 99);
        sel  = 1'($urandom);
        host = ($urandom_range(0, 1) != 0) ? host_pool[$urandom_range(0, 3)] : $urandom;
        link = {sel, ($urandom_range(0, 1) != 0) ? link_pool[$urandom_range(0, 3)]
                                                  : 7'($urandom)};
        sock = ($urandom_range(0, 19) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
        if (r < insert_pct[round]) begin
          op = cte_pkg::OP_INSERT;
        end else if (r < insert_pct[round] + 20) begin
          op = cte_pkg::OP_REMOVE;
        end else if (r < 95) begin
          op = cte_pkg::OP_LOOKUP;
          k  = $urandom_range(0, 2*ENTRIES - 1);
          case ($urandom_range(0, 5))
            0: ;
            1: begin
              link = cte_pkg::LINK_EMPTY_SEARCH;
              if ($urandom_range(0, 1) != 0) sock = 16'h0;
            end
            default: begin
              host = conn_host[k];
              link = conn_link[k];
              case ($urandom_range(0, 2))
                0: sock = 16'h0;
                1: sock = conn_sock[k];
                default: ;
              endcase
            end
          endcase
        end else begin
          op = OP_UNUSED;
        end
        send_word(op, host, link, sock, 5'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    errors         = 0;
    idle_cycles    = 0;
    no_idle        = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_op          = '0;
    in_host        = '0;
    in_link        = '0;
    in_socket_id   = '0;
    in_entry_index = '0;
    for (int i = 0; i < 2*ENTRIES; i++) begin
      conn_host[i] = '0;
      conn_link[i] = '0;
      conn_sock[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_table_full();
    test_random();

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cte_pkg.sv
rtl/cte_ctrl.sv
rtl/cte_datapath.sv
rtl/connection_table_engine_core.sv
tb/tb_connection_table_engine_core.sv
